### rtl/mqtt_inbound_packet_parser_macros.svh
// assertion macros for the inbound packet parser
// each use samples on clk_i and is disabled while rst_ni is low
`ifndef MQTT_INBOUND_PACKET_PARSER_MACROS_SVH
`define MQTT_INBOUND_PACKET_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every sampled edge out of reset
`define MIP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mip assertion failed");

// condition must never be seen out of reset
`define MIP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("mip forbidden condition seen");

`else

`define MIP_ASSERT(lbl, prop)
`define MIP_ASSERT_NEVER(lbl, cond)

`endif

`endif

### rtl/mip_pkg.sv
package mip_pkg;

  // end offset: header length plus 28-bit remaining length
  localparam int END_W = 29;
  // payload start offset: header, topic length, topic and packet id
  localparam int PS_W = 17;

  localparam logic [3:0]  TYPE_PUBLISH  = 4'h3;
  localparam logic [3:0]  TYPE_SUBACK   = 4'h9;
  localparam logic [3:0]  TYPE_PINGRESP = 4'hD;
  localparam logic [31:0] WAKE_RESET    = 32'h7761_6B65;
  localparam logic [2:0]  WAKE_BYTES    = 3'd4;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY,
    PH_IDLE
  } phase_e;

  typedef enum logic [2:0] {
    EV_IGNORED   = 3'd0,
    EV_WAKE      = 3'd1,
    EV_OTHER     = 3'd2,
    EV_SUBACK    = 3'd3,
    EV_PINGRESP  = 3'd4,
    EV_MALFORMED = 3'd5
  } event_e;

  // per-packet parse state
  typedef struct packed {
    phase_e      phase;
    logic [7:0]  header_byte;
    logic [27:0] rem_len;
    logic [2:0]  length_byte_count;
    logic        length_error;
    logic [15:0] topic_len;
    logic [15:0] packet_identifier;
    logic [2:0]  payload_count;   // saturates at four, only the first four bytes compare
    logic        payload_match;
    logic        publish_error;
  } parse_t;

  localparam parse_t PARSE_RESET = '{
    phase:             PH_HEADER,
    header_byte:       8'h00,
    rem_len:           28'h0,
    length_byte_count: 3'd0,
    length_error:      1'b0,
    topic_len:         16'h0,
    packet_identifier: 16'h0,
    payload_count:     3'd0,
    payload_match:     1'b1,
    publish_error:     1'b0
  };

  // one verdict per packet
  typedef struct packed {
    event_e      event_res;
    logic        header_ok;
    logic        ack_needed;
    logic [15:0] ack_packet_id;
    logic [1:0]  publish_qos;
    logic [27:0] length_field;
  } res_t;

  // fixed header length: type byte plus length bytes
  function automatic logic [2:0] header_len(input logic [2:0] lbc);
    return 3'd1 + lbc;
  endfunction

  // offset one past the last byte that the remaining length covers
  function automatic logic [END_W-1:0] packet_end(input logic [2:0] lbc,
                                                  input logic [27:0] rl);
    return END_W'(header_len(lbc)) + END_W'(rl);
  endfunction

  // offset of the first payload byte
  function automatic logic [PS_W-1:0] payload_start(input logic [2:0] lbc,
                                                    input logic [1:0] qos,
                                                    input logic [15:0] tl);
    logic [PS_W-1:0] id_len;
    id_len = (qos != 2'd0) ? PS_W'(2) : PS_W'(0);
    return PS_W'(header_len(lbc)) + PS_W'(2) + PS_W'(tl) + id_len;
  endfunction

endpackage

### rtl/mip_parse.sv
module mip_parse import mip_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 512,
  parameter int MAX_LENGTH_BYTES = 4,
  localparam int CW = $clog2(MAX_PACKET_BYTES + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    data_byte_i,
  input  logic          last_byte_i,
  input  logic [31:0]   wake_word_i,
  output parse_t        state_o,
  output logic [CW-1:0] count_o
);

  parse_t          st_q, st_d;
  logic [CW-1:0]   cnt_q, cnt_d;

  logic [2:0]       hl;
  logic [END_W-1:0] end_w;
  logic [END_W-1:0] pos;
  logic [PS_W-1:0]  ps_cur;
  logic [PS_W-1:0]  ps_new;
  logic [PS_W-1:0]  id_pos;
  logic [15:0]      tl_new;
  logic [2:0]       lbc_inc;
  logic [27:0]      rl_add;
  logic [31:0]      wake_sh;
  logic             qos_on;
  logic             keep;

  // byte offsets derived from the current state
  always_comb begin
    hl      = header_len(st_q.length_byte_count);
    end_w   = packet_end(st_q.length_byte_count, st_q.rem_len);
    pos     = END_W'(cnt_q);
    qos_on  = st_q.header_byte[2:1] != 2'd0;
    tl_new  = {st_q.topic_len[15:8], data_byte_i};
    ps_cur  = payload_start(st_q.length_byte_count, st_q.header_byte[2:1],
                            st_q.topic_len);
    ps_new  = payload_start(st_q.length_byte_count, st_q.header_byte[2:1], tl_new);
    id_pos  = PS_W'(hl) + PS_W'(2) + PS_W'(st_q.topic_len);
    lbc_inc = st_q.length_byte_count + 3'd1;
    keep    = cnt_q < CW'(MAX_PACKET_BYTES);
    wake_sh = wake_word_i >> {~st_q.payload_count[1:0], 3'b000};
  end

  // 7-bit length group placed by its index
  always_comb begin
    unique case (st_q.length_byte_count[1:0])
      2'd0:    rl_add = {21'h0, data_byte_i[6:0]};
      2'd1:    rl_add = {14'h0, data_byte_i[6:0], 7'h0};
      2'd2:    rl_add = {7'h0, data_byte_i[6:0], 14'h0};
      default: rl_add = {data_byte_i[6:0], 21'h0};
    endcase
  end

  // state update for one kept byte
  always_comb begin
    st_d  = st_q;
    cnt_d = cnt_q;
    if (keep) begin
      cnt_d = cnt_q + CW'(1);
      unique case (st_q.phase)
        PH_HEADER: begin
          st_d.header_byte = data_byte_i;
          st_d.phase       = PH_LENGTH;
        end
        PH_LENGTH: begin
          st_d.rem_len           = st_q.rem_len | rl_add;
          st_d.length_byte_count = lbc_inc;
          if (!data_byte_i[7]) begin
            st_d.phase = (st_q.header_byte[7:4] == TYPE_PUBLISH) ? PH_BODY : PH_IDLE;
          end else if (lbc_inc >= 3'(MAX_LENGTH_BYTES)) begin
            st_d.length_error = 1'b1;
            st_d.phase        = PH_IDLE;
          end
        end
        PH_BODY: begin
          if (pos == END_W'(hl)) begin
            st_d.topic_len = {data_byte_i, 8'h00};
          end else if (pos == END_W'(hl) + END_W'(1)) begin
            st_d.topic_len = tl_new;
            if (END_W'(ps_new) > end_w) begin
              st_d.publish_error = 1'b1;
            end
          end else begin
            // packet id follows the topic when qos is nonzero
            if (qos_on) begin
              if (pos == END_W'(id_pos)) begin
                st_d.packet_identifier = {data_byte_i, 8'h00};
              end else if (pos == END_W'(id_pos) + END_W'(1)) begin
                st_d.packet_identifier = {st_q.packet_identifier[15:8], data_byte_i};
              end
            end
            // payload bytes against the wake word
            if (pos >= END_W'(ps_cur) && pos < end_w) begin
              if (st_q.payload_count < WAKE_BYTES) begin
                if (data_byte_i != wake_sh[7:0]) begin
                  st_d.payload_match = 1'b0;
                end
                st_d.payload_count = st_q.payload_count + 3'd1;
              end
            end
          end
        end
        default: begin
          st_d = st_q;
        end
      endcase
    end
  end

  // parse state, cleared after the last byte of a packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= PARSE_RESET;
      cnt_q <= '0;
    end else if (fire_i) begin
      if (last_byte_i) begin
        st_q  <= PARSE_RESET;
        cnt_q <= '0;
      end else begin
        st_q  <= st_d;
        cnt_q <= cnt_d;
      end
    end
  end

  assign state_o = st_d;
  assign count_o = cnt_d;

endmodule

### rtl/mip_verdict.sv
module mip_verdict import mip_pkg::*; #(
  parameter int CW = 10
) (
  input  parse_t        state_i,
  input  logic [CW-1:0] count_i,
  output res_t          res_o
);

  logic [END_W-1:0] end_w;
  logic [END_W-1:0] n;
  logic [PS_W-1:0]  ps;
  logic [2:0]       hl;

  always_comb begin
    hl    = header_len(state_i.length_byte_count);
    end_w = packet_end(state_i.length_byte_count, state_i.rem_len);
    n     = END_W'(count_i);
    ps    = payload_start(state_i.length_byte_count, state_i.header_byte[2:1],
                          state_i.topic_len);
  end

  // verdict on the fully parsed packet
  always_comb begin
    res_o           = '0;
    res_o.event_res = EV_IGNORED;
    if (n < END_W'(2)) begin
      res_o.event_res = EV_IGNORED;
    end else if (state_i.phase == PH_LENGTH || state_i.length_error) begin
      res_o.event_res = EV_MALFORMED;
    end else begin
      res_o.header_ok    = 1'b1;
      res_o.length_field = state_i.rem_len;
      unique case (state_i.header_byte[7:4])
        TYPE_PUBLISH: begin
          res_o.publish_qos = state_i.header_byte[2:1];
          if (end_w > n || END_W'(hl) + END_W'(2) > n || state_i.publish_error) begin
            res_o.event_res = EV_MALFORMED;
          end else begin
            res_o.event_res = (end_w == END_W'(ps) + END_W'(4) && state_i.payload_match)
                              ? EV_WAKE : EV_OTHER;
            if (state_i.header_byte[2:1] == 2'd1) begin
              res_o.ack_needed    = 1'b1;
              res_o.ack_packet_id = state_i.packet_identifier;
            end
          end
        end
        TYPE_SUBACK:   res_o.event_res = EV_SUBACK;
        TYPE_PINGRESP: res_o.event_res = EV_PINGRESP;
        default:       res_o.event_res = EV_IGNORED;
      endcase
    end
  end

endmodule

### rtl/mqtt_inbound_packet_parser.sv
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+--------------------------------------
// in       | input     | in_valid_i / in_stall_o   | data_byte_i, last_byte_i
// out      | output    | out_valid_o / out_stall_i | event_res_o, header_ok_o, ack_*_o, ...
// config   | input     | wake_word_we_i            | wake_word_i
//
// one byte per cycle unless a last byte waits on a stalled output: a byte sits in the
// input register, the parse state and the verdict are computed from it, and the verdict
// of a last byte lands in the result register. out_valid_o rises when that verdict is loaded.
// bytes that are not last keep flowing while a verdict waits on a stalled output;
// a last byte waits in the input register until the result register is free.
// reset clears the parse state and loads the default wake word; no clearing pass.
`include "mqtt_inbound_packet_parser_macros.svh"

module mqtt_inbound_packet_parser import mip_pkg::*; #(
  parameter int MAX_PACKET_BYTES = 512,
  parameter int MAX_LENGTH_BYTES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        wake_word_we_i,
  input  logic [31:0] wake_word_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  event_res_o,
  output logic        header_ok_o,
  output logic        ack_needed_o,
  output logic [15:0] ack_packet_id_o,
  output logic [1:0]  publish_qos_o,
  output logic [27:0] length_field_o
);

  localparam int CW = $clog2(MAX_PACKET_BYTES + 1);

  logic [31:0]   wake_q;
  logic          in_vld_q;
  logic [7:0]    byte_q;
  logic          last_q;
  logic          out_vld_q;
  res_t          res_q;
  res_t          res_d;
  parse_t        st_d;
  logic [CW-1:0] cnt_d;
  logic          proc_fire;
  logic          in_xfer;

  // wake word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wake_q <= WAKE_RESET;
    end else if (wake_word_we_i) begin
      wake_q <= wake_word_i;
    end
  end

  // a last byte needs room in the result register
  assign proc_fire  = in_vld_q & (~last_q | ~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~proc_fire;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_xfer) begin
      in_vld_q <= 1'b1;
    end else if (proc_fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  mip_parse #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES),
    .MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (proc_fire),
    .data_byte_i (byte_q),
    .last_byte_i (last_q),
    .wake_word_i (wake_q),
    .state_o     (st_d),
    .count_o     (cnt_d)
  );

  mip_verdict #(
    .CW(CW)
  ) u_verdict (
    .state_i (st_d),
    .count_i (cnt_d),
    .res_o   (res_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (proc_fire && last_q) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && last_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_vld_q;
  assign event_res_o     = res_q.event_res;
  assign header_ok_o     = res_q.header_ok;
  assign ack_needed_o    = res_q.ack_needed;
  assign ack_packet_id_o = res_q.ack_packet_id;
  assign publish_qos_o   = res_q.publish_qos;
  assign length_field_o  = res_q.length_field;

  // a verdict only appears after a last byte is processed
  `MIP_ASSERT(a_result_from_last, $rose(out_vld_q) |-> $past(proc_fire && last_q))
  // bytes inside a packet never wait on the output side
  `MIP_ASSERT_NEVER(a_mid_byte_stall, in_vld_q && !last_q && in_stall_o)
  // an ack only comes with a well-formed qos 1 publish
  `MIP_ASSERT(a_ack_publish, out_valid_o && ack_needed_o |->
    (event_res_o == EV_WAKE || event_res_o == EV_OTHER) && publish_qos_o == 2'd1)
  // no decoded length without a clean header
  `MIP_ASSERT(a_len_needs_hdr, out_valid_o && !header_ok_o |->
    length_field_o == 28'h0 && !ack_needed_o && publish_qos_o == 2'd0)

endmodule
